// ===== design/mme_pkg.sv =====
// Package for the matrix multiply engine: sizes, codes, widths.
// No dependencies.
`default_nettype none
package mme_pkg;
    localparam int MAX_DIM   = 16;
    localparam int FRAC_BITS = 8;
    localparam int IDX_W     = $clog2(MAX_DIM);
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int DEPTH     = MAX_DIM * MAX_DIM;
    localparam int SIZE_W    = 5;
    localparam int ACC_W     = 48;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 5;

    localparam logic [1:0] ACT_LOAD_A = 2'd0;
    localparam logic [1:0] ACT_LOAD_B = 2'd1;
    localparam logic [1:0] ACT_LOAD_C = 2'd2;
    localparam logic [1:0] ACT_COMPUTE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INNER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TMODE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OMODE = 3'd4;

    localparam logic [1:0] TM_PLAIN = 2'd0;
    localparam logic [1:0] TM_A_T   = 2'd1;
    localparam logic [1:0] TM_B_T   = 2'd2;
    localparam logic [1:0] TM_SPARE = 2'd3;   // unused, acts as plain
    localparam logic [1:0] OM_OVER  = 2'd0;
    localparam logic [1:0] OM_ADD   = 2'd1;
    localparam logic [1:0] OM_ACC   = 2'd2;
    localparam logic [1:0] OM_SPARE = 2'd3;   // unused, acts as overwrite

    // token handed from cell to cell along the dot-product chain
    typedef struct packed {
        logic                    vld;
        logic                    last;
        logic signed [ACC_W-1:0] acc;
    } t_mac_tok;
endpackage
`default_nettype wire

// ===== design/mme_if.sv =====
// Valid/ready channel interfaces for the input words and the output elements.
// No dependencies.
`default_nettype none
interface mme_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [3:0]  row;
    logic [3:0]  col;
    logic signed [15:0] value;
    modport source (output valid, action, row, col, value, input ready);
    modport sink   (input valid, action, row, col, value, output ready);
endinterface

interface mme_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  out_row;
    logic [3:0]  out_col;
    logic signed [15:0] out_value;
    logic        saturated;
    modport source (output valid, out_row, out_col, out_value, saturated, input ready);
    modport sink   (input valid, out_row, out_col, out_value, saturated, output ready);
endinterface
`default_nettype wire

// ===== design/mme_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module mme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== design/mme_cell.sv =====
// One multiply-accumulate cell of the chain: registered product, then add.
// Depends on mme_pkg.
`default_nettype none
module mme_cell
    import mme_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic signed [15:0] i_a,
    input  wire logic signed [15:0] i_b,
    input  wire t_mac_tok           i_tok,
    output t_mac_tok                o_tok
);
    logic signed [31:0] r_prod;
    t_mac_tok           r_mid;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid.vld   <= 1'b0;
            o_tok.vld   <= 1'b0;
        end else begin
            r_mid.vld <= i_tok.vld;
            o_tok.vld <= r_mid.vld;
        end
        r_mid.last <= i_tok.last;
        r_mid.acc  <= i_tok.acc;
        r_prod     <= i_en ? i_a * i_b : 32'sd0;
        o_tok.last <= r_mid.last;
        o_tok.acc  <= r_mid.acc + ACC_W'(r_prod);
    end
endmodule
`default_nettype wire

// ===== design/matrix_multiply_engine.sv =====
// Top level of the matrix multiply engine: stores, sequencer, MAC cells, output.
// Depends on mme_pkg, mme_if, mme_ram and mme_cell.
`default_nettype none
// Loads are taken while the sequencer is idle (A, B, C stores are 256-entry
// RAMs). A compute word walks the inner index with one RAM read of A and B
// per cycle; the products stream through a chain of two MAC cells (even and
// odd inner indices, accumulator handed down the chain) into a running sum,
// which is rounded and clipped once the last index pair has closed. The
// sequencer is idle again for the next word once the result is registered
// at the output, or after a C write-back state in accumulate mode.
// One element is in flight at a time; the result sits in an output register,
// so loads are still taken while it waits, but a compute word is held off
// until the result has gone. Out-of-range computes give no result.
module matrix_multiply_engine
    import mme_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    mme_in_if.sink                    in_ch,
    mme_out_if.source                 out_ch
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;
    localparam logic [1:0] ST_WB   = 2'd3;

    logic [SIZE_W-1:0] r_rows, r_cols, r_inner;
    logic [1:0]        r_tmode, r_omode;
    logic [1:0]        r_state;
    logic [IDX_W-1:0]  r_row, r_col;
    logic [SIZE_W-1:0] r_kk, r_klen;
    logic [1:0]        r_tm, r_om;
    logic              r_ovld;

    function automatic logic [SIZE_W-1:0] eff(input logic [SIZE_W-1:0] v);
        if (v == '0) return SIZE_W'(1);
        if (v > SIZE_W'(MAX_DIM)) return SIZE_W'(MAX_DIM);
        return v;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows  <= SIZE_W'(16);
            r_cols  <= SIZE_W'(16);
            r_inner <= SIZE_W'(16);
            r_tmode <= TM_PLAIN;
            r_omode <= OM_OVER;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ROWS:  r_rows  <= i_cfg_data;
                REG_COLS:  r_cols  <= i_cfg_data;
                REG_INNER: r_inner <= i_cfg_data;
                REG_TMODE: r_tmode <= i_cfg_data[1:0];
                REG_OMODE: r_omode <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    wire acc_in = in_ch.valid && in_ch.ready;
    wire is_cmp = in_ch.action == ACT_COMPUTE;
    wire in_rng = (SIZE_W'(in_ch.row) < eff(r_rows)) && (SIZE_W'(in_ch.col) < eff(r_cols));
    assign in_ch.ready = (r_state == ST_IDLE) && !(is_cmp && r_ovld);

    // store addressing
    logic [IDX_W-1:0]  kidx;
    logic [ADDR_W-1:0] a_ra, b_ra, w_a, c_ra;
    assign kidx = r_kk[IDX_W-1:0];
    assign a_ra = (r_tm == TM_A_T) ? {kidx, r_row} : {r_row, kidx};
    assign b_ra = (r_tm == TM_B_T) ? {r_col, kidx} : {kidx, r_col};
    assign c_ra = {r_row, r_col};
    assign w_a  = {in_ch.row, in_ch.col};

    logic [15:0] a_q, b_q, c_q;
    logic [15:0] wb_val;
    wire we_a = acc_in && in_ch.action == ACT_LOAD_A;
    wire we_b = acc_in && in_ch.action == ACT_LOAD_B;
    wire we_c = (acc_in && in_ch.action == ACT_LOAD_C) || (r_state == ST_WB);

    mme_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_a (.i_clk, .i_we(we_a), .i_waddr(w_a),
        .i_wdata(in_ch.value), .i_raddr(a_ra), .o_rdata(a_q));
    mme_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_b (.i_clk, .i_we(we_b), .i_waddr(w_a),
        .i_wdata(in_ch.value), .i_raddr(b_ra), .o_rdata(b_q));
    mme_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_c (.i_clk, .i_we(we_c),
        .i_waddr((r_state == ST_WB) ? c_ra : w_a),
        .i_wdata((r_state == ST_WB) ? wb_val : in_ch.value),
        .i_raddr(c_ra), .o_rdata(c_q));

    // issue stage: read address this cycle, data next cycle
    logic r_iss, r_iss_last, r_iss_odd;
    t_mac_tok tok0, tok1, tok2;
    assign tok0.vld  = r_iss && !r_iss_odd;
    assign tok0.last = r_iss_last;
    assign tok0.acc  = '0;

    // chain of two cells; cell 0 takes even indices, cell 1 odd ones.
    // A token carries the running sum of one index pair.
    mme_cell u_c0 (.i_clk, .i_rst_n, .i_en(r_iss && !r_iss_odd),
        .i_a(a_q), .i_b(b_q), .i_tok(tok0), .o_tok(tok1));
    logic signed [15:0] r_a1, r_b1;
    logic r_en1;
    always_ff @(posedge i_clk) begin
        r_a1 <= a_q; r_b1 <= b_q; r_en1 <= r_iss && r_iss_odd;
    end
    // odd element arrives behind its even partner and is registered once more, lined up with tok1
    t_mac_tok tok1d;
    always_comb begin
        tok1d = tok1;
    end
    mme_cell u_c1 (.i_clk, .i_rst_n, .i_en(r_en1 && tok1.vld),
        .i_a(r_a1), .i_b(r_b1), .i_tok(tok1d), .o_tok(tok2));

    logic signed [ACC_W-1:0] r_sum;
    logic r_done;
    logic signed [ACC_W-1:0] tot;
    logic signed [ACC_W-1:0] rnd;
    logic sat_hi, sat_lo;
    assign tot = r_sum + ((r_om != OM_OVER) ? (ACC_W'(signed'(c_q)) <<< FRAC_BITS) : '0);
    assign rnd = (tot + ACC_W'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
    assign sat_hi = rnd > ACC_W'(32767);
    assign sat_lo = rnd < -ACC_W'(32768);
    assign wb_val = sat_hi ? 16'h7fff : sat_lo ? 16'h8000 : rnd[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_iss   <= 1'b0;
            r_ovld  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= tok2.vld && tok2.last;
            if (r_state == ST_FIN && r_done) r_ovld <= 1'b1;
            else if (out_ch.valid && out_ch.ready) r_ovld <= 1'b0;
            if (tok2.vld) begin
                r_sum <= r_sum + tok2.acc;
            end
            unique case (r_state)
                ST_IDLE: begin
                    r_iss <= 1'b0;
                    if (acc_in && is_cmp && in_rng) begin
                        r_state <= ST_RUN;
                        r_row <= in_ch.row; r_col <= in_ch.col;
                        r_kk <= '0; r_klen <= eff(r_inner);
                        r_tm <= (r_tmode == TM_SPARE) ? TM_PLAIN : r_tmode;
                        r_om <= (r_omode == OM_SPARE) ? OM_OVER : r_omode;
                        r_sum <= '0;
                    end
                end
                ST_RUN: begin
                    // an odd count ends on an even slot; cell 1 then adds zero
                    r_iss      <= 1'b1;
                    r_iss_odd  <= r_kk[0];
                    r_iss_last <= (r_kk + SIZE_W'(2) >= r_klen);
                    if (r_kk + 1'b1 >= r_klen) r_state <= ST_FIN;
                    r_kk <= r_kk + 1'b1;
                end
                ST_FIN: begin
                    r_iss <= 1'b0;
                    if (r_done) begin
                        out_ch.out_row <= r_row;
                        out_ch.out_col <= r_col;
                        out_ch.out_value <= wb_val;
                        out_ch.saturated <= sat_hi || sat_lo;
                        r_state <= (r_om == OM_ACC) ? ST_WB : ST_IDLE;
                    end
                end
                ST_WB: r_state <= ST_IDLE;
                default: r_state <= ST_IDLE;
            endcase
        end
    end
    assign out_ch.valid = r_ovld;
endmodule
`default_nettype wire

// ===== design/mme_checker.sv =====
// Port-level assertions for the matrix multiply engine, bound to the top.
// Depends on mme_pkg.
`default_nettype none
module mme_checker
    import mme_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic [15:0] out_value,
    input wire logic sat
);
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !out_valid)
        else $error("valid after reset");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_value))
        else $error("result dropped");
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && sat |-> (out_value == 16'h7fff || out_value == 16'h8000))
        else $error("bad clip");
endmodule
bind matrix_multiply_engine mme_checker u_chk (.i_clk, .i_rst_n,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_value(out_ch.out_value), .sat(out_ch.saturated));
`default_nettype wire

// ===== test/matrix_multiply_engine_tb.sv =====
// Self-checking testbench for matrix_multiply_engine: loads A/B/C, issues
// compute words and checks every result against a built-in predictor.
// Depends on mme_pkg, mme_if and the engine RTL.
`timescale 1ns / 1ps
`default_nettype none
module matrix_multiply_engine_tb;
    import mme_pkg::*;

    localparam int CYCLE_LIMIT  = 900000;
    localparam int DRAIN_CYCLES = 40;         // settle time after the queues have drained
    localparam int ITEM_TARGET  = 1700;

    typedef struct {
        logic [1:0]         action;
        logic [3:0]         row;
        logic [3:0]         col;
        logic signed [15:0] value;
    } t_word;

    typedef struct {
        logic [3:0]         row;
        logic [3:0]         col;
        logic signed [15:0] value;
        logic               sat;
    } t_elem;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    mme_in_if  in_ch();
    mme_out_if out_ch();

    matrix_multiply_engine u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch)
    );

    // predictor state: stores and register copies
    logic signed [15:0] a_mem [DEPTH];
    logic signed [15:0] b_mem [DEPTH];
    logic signed [15:0] c_mem [DEPTH];
    logic [4:0] p_rows, p_cols, p_inner;
    logic [1:0] p_tmode, p_omode;

    // stimulus side bookkeeping of which entries hold data
    bit wr_a [DEPTH];
    bit wr_b [DEPTH];
    bit wr_c [DEPTH];

    t_word pending_words[$];
    t_elem expected_elems[$];

    int errors;
    int words_sent;
    int elems_seen;
    int phases_run;
    int cycle_cnt;
    int src_gap, snk_gap;
    int src_max, snk_max;
    int snk_hold;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int eff_size(logic [4:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return v;
    endfunction

    function automatic logic [1:0] eff_tmode();
        return (p_tmode == TM_SPARE) ? TM_PLAIN : p_tmode;
    endfunction

    function automatic logic [1:0] eff_omode();
        return (p_omode == OM_SPARE) ? OM_OVER : p_omode;
    endfunction

    task automatic report_mismatch(string what, longint exp_v, longint got_v);
        $display("mismatch %s: expected %0d got %0d at cycle %0d", what, exp_v, got_v,
                 cycle_cnt);
        errors++;
    endtask

    // Apply one accepted word to the predictor; compute words queue a result.
    task automatic apply_word(t_word w);
        int n, m, k, ai, bi, ci;
        longint acc, res;
        t_elem e;
        n = eff_size(p_rows);
        m = eff_size(p_cols);
        k = eff_size(p_inner);
        ci = w.row * MAX_DIM + w.col;
        case (w.action)
            ACT_LOAD_A: a_mem[ci] = w.value;
            ACT_LOAD_B: b_mem[ci] = w.value;
            ACT_LOAD_C: c_mem[ci] = w.value;
            default: begin
                if (w.row < n && w.col < m) begin
                    acc = 0;
                    for (int kk = 0; kk < k; kk++) begin
                        ai = (eff_tmode() == TM_A_T) ? kk * MAX_DIM + w.row
                                                     : w.row * MAX_DIM + kk;
                        bi = (eff_tmode() == TM_B_T) ? w.col * MAX_DIM + kk
                                                     : kk * MAX_DIM + w.col;
                        acc += longint'(a_mem[ai]) * longint'(b_mem[bi]);
                    end
                    if (eff_omode() != OM_OVER) acc += longint'(c_mem[ci]) <<< FRAC_BITS;
                    acc += longint'(1) <<< (FRAC_BITS - 1);
                    res = acc >>> FRAC_BITS;    // arithmetic shift floors
                    e.sat = 1'b0;
                    if (res > 32767) begin
                        res = 32767;
                        e.sat = 1'b1;
                    end
                    if (res < -32768) begin
                        res = -32768;
                        e.sat = 1'b1;
                    end
                    e.row = w.row;
                    e.col = w.col;
                    e.value = res[15:0];
                    if (eff_omode() == OM_ACC) c_mem[ci] = e.value;
                    expected_elems.push_back(e);
                end
            end
        endcase
    endtask

    // Input driver: a new word goes out once the previous one was taken and
    // its random gap has run down.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            src_gap <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                apply_word('{in_ch.action, in_ch.row, in_ch.col, in_ch.value});
                words_sent++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    in_ch.valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    t_word w;
                    w = pending_words.pop_front();
                    in_ch.valid  <= 1'b1;
                    in_ch.action <= w.action;
                    in_ch.row    <= w.row;
                    in_ch.col    <= w.col;
                    in_ch.value  <= w.value;
                    src_gap <= $urandom_range(0, src_max);
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: checks each taken element against the oldest expectation,
    // then decides ready for the next cycle (random gaps, long hold-off).
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            snk_gap <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                elems_seen++;
                if (expected_elems.size() == 0) begin
                    report_mismatch("unexpected element row", -1, out_ch.out_row);
                end else begin
                    t_elem e;
                    e = expected_elems.pop_front();
                    if (out_ch.out_row !== e.row)
                        report_mismatch("out_row", e.row, out_ch.out_row);
                    if (out_ch.out_col !== e.col)
                        report_mismatch("out_col", e.col, out_ch.out_col);
                    if (out_ch.out_value !== e.value)
                        report_mismatch("out_value", e.value, out_ch.out_value);
                    if (out_ch.saturated !== e.sat)
                        report_mismatch("saturated", e.sat, out_ch.saturated);
                end
                snk_gap <= $urandom_range(0, snk_max);
                out_ch.ready <= 1'b0;
            end else if (snk_hold > 0) begin
                snk_hold <= snk_hold - 1;
                out_ch.ready <= 1'b0;
            end else if (snk_gap > 0) begin
                snk_gap <= snk_gap - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("status: fail");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_ROWS:  p_rows  = data;
            REG_COLS:  p_cols  = data;
            REG_INNER: p_inner = data;
            REG_TMODE: p_tmode = data[1:0];
            default:   p_omode = data[1:0];
        endcase
    endtask

    task automatic push_word(logic [1:0] act, int r, int c, logic [15:0] v);
        int idx;
        idx = r * MAX_DIM + c;
        pending_words.push_back('{act, r[3:0], c[3:0], v});
        case (act)
            ACT_LOAD_A: wr_a[idx] = 1'b1;
            ACT_LOAD_B: wr_b[idx] = 1'b1;
            ACT_LOAD_C: wr_c[idx] = 1'b1;
            default: ;
        endcase
    endtask

    function automatic logic [15:0] draw_value();
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: case ($urandom_range(0, 3))
                   0: return 16'h7fff;
                   1: return 16'h8000;
                   2: return 16'hffff;
                   default: return 16'h0000;
               endcase
            default: return 16'($urandom_range(0, 2047)) - 16'd1024;
        endcase
    endfunction

    // block until the engine has drained everything, then settle
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_words.size() > 0 || in_ch.valid || expected_elems.size() > 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One job: program all registers, load the operand region the mode reads,
    // then a random mix of computes, stray computes and reloads.
    task automatic run_phase(logic [4:0] rn, logic [4:0] cm, logic [4:0] ik,
                             logic [1:0] tm, logic [1:0] om, int mix, bit busy);
        int n, m, k, r, c;
        write_reg(REG_ROWS, rn);
        write_reg(REG_COLS, cm);
        write_reg(REG_INNER, ik);
        write_reg(REG_TMODE, CFG_W'(tm));
        write_reg(REG_OMODE, CFG_W'(om));
        src_max = busy ? 0 : 10;
        snk_max = busy ? 0 : 10;
        n = eff_size(rn);
        m = eff_size(cm);
        k = eff_size(ik);
        for (int i = 0; i < n; i++)
            for (int kk = 0; kk < k; kk++) begin
                r = (eff_tmode() == TM_A_T) ? kk : i;
                c = (eff_tmode() == TM_A_T) ? i : kk;
                if (!wr_a[r * MAX_DIM + c] || $urandom_range(0, 1))
                    push_word(ACT_LOAD_A, r, c, draw_value());
            end
        for (int j = 0; j < m; j++)
            for (int kk = 0; kk < k; kk++) begin
                r = (eff_tmode() == TM_B_T) ? j : kk;
                c = (eff_tmode() == TM_B_T) ? kk : j;
                if (!wr_b[r * MAX_DIM + c] || $urandom_range(0, 1))
                    push_word(ACT_LOAD_B, r, c, draw_value());
            end
        if (eff_omode() != OM_OVER)
            for (int i = 0; i < n; i++)
                for (int j = 0; j < m; j++)
                    if (!wr_c[i * MAX_DIM + j] || $urandom_range(0, 1))
                        push_word(ACT_LOAD_C, i, j, draw_value());
        for (int it = 0; it < mix; it++) begin
            case ($urandom_range(0, 9))
                0: begin
                    // stray position; only reads stores when in range
                    r = $urandom_range(0, 15);
                    c = $urandom_range(0, 15);
                    push_word(ACT_COMPUTE, r, c, 16'($urandom));
                end
                1, 2: begin
                    // reload an entry of A, B or C somewhere
                    r = $urandom_range(0, 15);
                    c = $urandom_range(0, 15);
                    push_word(2'($urandom_range(0, 2)), r, c, draw_value());
                end
                default:
                    push_word(ACT_COMPUTE, $urandom_range(0, n - 1),
                              $urandom_range(0, m - 1), 16'($urandom));
            endcase
        end
        phases_run++;
        wait_idle();
    endtask

    initial begin
        int rn, cm, ik;
        errors = 0;
        words_sent = 0;
        elems_seen = 0;
        phases_run = 0;
        cycle_cnt = 0;
        snk_hold = 0;
        src_max = 10;
        snk_max = 10;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.action = ACT_LOAD_A;
        in_ch.row = '0;
        in_ch.col = '0;
        in_ch.value = '0;
        out_ch.ready = 1'b0;
        p_rows = 16;
        p_cols = 16;
        p_inner = 16;
        p_tmode = TM_PLAIN;
        p_omode = OM_OVER;
        for (int i = 0; i < DEPTH; i++) begin
            a_mem[i] = '0;
            b_mem[i] = '0;
            c_mem[i] = '0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: 2x2x2 with add-C, full-scale operands to hit both clamps
        write_reg(REG_ROWS, 5'd2);
        write_reg(REG_COLS, 5'd2);
        write_reg(REG_INNER, 5'd2);
        write_reg(REG_TMODE, CFG_W'(TM_PLAIN));
        write_reg(REG_OMODE, CFG_W'(OM_ADD));
        push_word(ACT_LOAD_A, 0, 0, 16'h7fff);
        push_word(ACT_LOAD_A, 0, 1, 16'h7fff);
        push_word(ACT_LOAD_A, 1, 0, 16'h8000);
        push_word(ACT_LOAD_A, 1, 1, 16'h0100);
        push_word(ACT_LOAD_B, 0, 0, 16'h7fff);
        push_word(ACT_LOAD_B, 1, 0, 16'h7fff);
        push_word(ACT_LOAD_B, 0, 1, 16'h0000);
        push_word(ACT_LOAD_B, 1, 1, 16'hff80);
        push_word(ACT_LOAD_C, 0, 0, 16'h8000);
        push_word(ACT_LOAD_C, 0, 1, 16'h7fff);
        push_word(ACT_LOAD_C, 1, 0, 16'h0001);
        push_word(ACT_LOAD_C, 1, 1, 16'hffff);
        push_word(ACT_COMPUTE, 0, 0, 16'h0);
        push_word(ACT_COMPUTE, 0, 1, 16'hffff);
        push_word(ACT_COMPUTE, 1, 0, 16'h0);
        push_word(ACT_COMPUTE, 1, 1, 16'h0);
        push_word(ACT_COMPUTE, 2, 0, 16'h0);    // row past rows_n: no result
        push_word(ACT_COMPUTE, 0, 15, 16'h0);   // col past cols_m: no result
        push_word(ACT_LOAD_A, 15, 15, 16'h1234);
        wait_idle();

        // extremes of the registers, including zero and oversize values
        run_phase(5'd1, 5'd1, 5'd1, TM_PLAIN, OM_OVER, 10, 1'b0);
        run_phase(5'd0, 5'd0, 5'd0, TM_SPARE, OM_SPARE, 10, 1'b0);
        run_phase(5'd16, 5'd16, 5'd16, TM_A_T, OM_ACC, 40, 1'b0);
        run_phase(5'd31, 5'd17, 5'd16, TM_B_T, OM_ADD, 40, 1'b1);

        // back pressure: hold the output off while words keep coming
        fork
            run_phase(5'd4, 5'd4, 5'd3, TM_PLAIN, OM_ACC, 60, 1'b1);
            begin
                @(negedge i_clk);
                snk_hold = 600;
            end
        join

        while (words_sent < ITEM_TARGET) begin
            rn = $urandom_range(1, 5);
            cm = $urandom_range(1, 5);
            ik = $urandom_range(0, 8) == 0 ? $urandom_range(0, 31) : $urandom_range(1, 6);
            run_phase(rn[4:0], cm[4:0], ik[4:0], 2'($urandom_range(0, 3)),
                      2'($urandom_range(0, 3)), $urandom_range(20, 80),
                      $urandom_range(0, 4) == 0);
        end

        if (expected_elems.size() > 0)
            report_mismatch("elements never returned", 0, expected_elems.size());
        $display("covered %0d words in %0d jobs, %0d elements checked, %0d errors",
                 words_sent, phases_run, elems_seen, errors);
        $display("all transpose and output modes, sizes 0 to 31, full back pressure");
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire
